// ===== rtl/lrsr_pkg.sv =====
`default_nettype none
package lrsr_pkg;

  localparam int STATES_DEF       = 64;
  localparam int TERMINALS_DEF    = 32;
  localparam int NONTERMINALS_DEF = 16;
  localparam int RULES_DEF        = 64;
  localparam int STACK_DEPTH_DEF  = 64;

  localparam int STATE_W = 6;
  localparam int COL_W   = 5;
  localparam int RULE_W  = 6;
  localparam int LHS_W   = 4;
  localparam int LEN_W   = 4;
  localparam int RED_W   = 6;
  localparam int MAX_RED = 63;

  localparam int ACT_ENTRY_W  = 8;
  localparam int GOTO_ENTRY_W = 7;
  localparam int RULE_ENTRY_W = 8;

  localparam logic [1:0] GOTO_KIND_VALID = 2'd1;

  typedef enum logic [1:0] {
    MODE_ACTION = 2'd0,
    MODE_GOTO   = 2'd1,
    MODE_RULE   = 2'd2,
    MODE_PARSE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_EMPTY  = 2'd0,
    ACT_SHIFT  = 2'd1,
    ACT_REDUCE = 2'd2,
    ACT_ACCEPT = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    RES_SHIFT  = 3'd0,
    RES_REDUCE = 3'd1,
    RES_ACCEPT = 3'd2,
    RES_ERROR  = 3'd3,
    RES_LOAD   = 3'd4
  } res_e;

  typedef struct packed {
    logic act_we;
    logic goto_we;
    logic rule_we;
    logic act_re;
    logic goto_re;
    logic rule_re;
  } tbl_ctl_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lrsr_tables.sv =====
`default_nettype none
module lrsr_tables import lrsr_pkg::*; #(
  parameter int STATES       = STATES_DEF,
  parameter int TERMINALS    = TERMINALS_DEF,
  parameter int NONTERMINALS = NONTERMINALS_DEF,
  parameter int RULES        = RULES_DEF,
  localparam int AAW = idx_w(STATES * TERMINALS),
  localparam int GAW = idx_w(STATES * NONTERMINALS),
  localparam int RAW = idx_w(RULES)
) (
  input  wire logic                    clk_i,
  input  wire tbl_ctl_t                ctl_i,
  input  wire logic [AAW-1:0]          act_waddr_i,
  input  wire logic [ACT_ENTRY_W-1:0]  act_wdata_i,
  input  wire logic [AAW-1:0]          act_raddr_i,
  output logic      [ACT_ENTRY_W-1:0]  act_rdata_o,
  input  wire logic [GAW-1:0]          goto_waddr_i,
  input  wire logic [GOTO_ENTRY_W-1:0] goto_wdata_i,
  input  wire logic [GAW-1:0]          goto_raddr_i,
  output logic      [GOTO_ENTRY_W-1:0] goto_rdata_o,
  input  wire logic [RAW-1:0]          rule_waddr_i,
  input  wire logic [RULE_ENTRY_W-1:0] rule_wdata_i,
  input  wire logic [RAW-1:0]          rule_raddr_i,
  output logic      [RULE_ENTRY_W-1:0] rule_rdata_o
);

  logic [ACT_ENTRY_W-1:0]  act_mem  [STATES*TERMINALS];
  logic [GOTO_ENTRY_W-1:0] goto_mem [STATES*NONTERMINALS];
  logic [RULE_ENTRY_W-1:0] rule_mem [RULES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.act_we) begin
      act_mem[act_waddr_i] <= act_wdata_i;
    end
    if (ctl_i.act_re) begin
      act_rdata_o <= act_mem[act_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.goto_we) begin
      goto_mem[goto_waddr_i] <= goto_wdata_i;
    end
    if (ctl_i.goto_re) begin
      goto_rdata_o <= goto_mem[goto_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rule_we) begin
      rule_mem[rule_waddr_i] <= rule_wdata_i;
    end
    if (ctl_i.rule_re) begin
      rule_rdata_o <= rule_mem[rule_raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lrsr_stack.sv =====
`default_nettype none
module lrsr_stack import lrsr_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int STKW = idx_w(STACK_DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [STKW-1:0]    waddr_i,
  input  wire logic [STATE_W-1:0] wdata_i,
  input  wire logic               re_i,
  input  wire logic [STKW-1:0]    raddr_i,
  output logic      [STATE_W-1:0] rdata_o
);

  logic [STATE_W-1:0] mem [STACK_DEPTH];
  logic [STATE_W-1:0] rd_q;
  logic               bottom_q;

  // the bottom entry always reads back as state 0; the engine never writes it
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q     <= mem[raddr_i];
      bottom_q <= (raddr_i == '0);
    end
  end

  assign rdata_o = bottom_q ? '0 : rd_q;

endmodule
`default_nettype wire

// ===== rtl/lr_shift_reduce_parse_engine.sv =====
// Table-driven LR shift-reduce parse engine. A load transaction (tuser 0, 1 or 2) writes one
// in-range action, goto or rule entry in its accept cycle and answers with one load-done result.
// A parse transaction (tuser 3) looks up the action for the state on top of the stack and the
// symbol; every reduction emits one result (rule and goto state, tlast low) and the transaction
// ends with one shift, accept or error result (tlast high). Tables and the state stack sit in
// single-port-read synchronous memories, so the top of the stack is kept in a register: a
// symbol that shifts, accepts or fails is settled by its action lookup, each reduction steps
// through action, rule, stack and goto reads in turn, and a reduction fails at the rule read on
// stack underflow or at the goto read on an empty goto or a full stack. The engine accepts a new
// transaction once the previous one is finished and the result register is free or being
// drained; a stalled output holds the sequencer. Accept and error return the stack to the
// single state 0. Entries never loaded read back as undefined.
`default_nettype none
module lr_shift_reduce_parse_engine import lrsr_pkg::*; #(
  parameter int STATES       = STATES_DEF,
  parameter int TERMINALS    = TERMINALS_DEF,
  parameter int NONTERMINALS = NONTERMINALS_DEF,
  parameter int RULES        = RULES_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // row_state[5:0] column[10:6] action_kind[12:11] target[18:13] rule_index[24:19]
  // rule_lhs[28:25] rule_length[32:29] symbol[37:33], zero fill [39:38]
  input  wire logic [39:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // kind[2:0] rule_number[8:3] new_state[14:9], zero fill [15]
  output logic [15:0]      m_axis_tdata,
  // last
  output logic             m_axis_tlast
);

  localparam int AAW  = idx_w(STATES * TERMINALS);
  localparam int GAW  = idx_w(STATES * NONTERMINALS);
  localparam int RAW  = idx_w(RULES);
  localparam int STKW = idx_w(STACK_DEPTH);
  localparam int SPW  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACT  = 5'b00010,
    ST_RULE = 5'b00100,
    ST_STK  = 5'b01000,
    ST_GOTO = 5'b10000
  } state_e;

  mode_e              in_mode;
  logic [STATE_W-1:0] in_row;
  logic [COL_W-1:0]   in_column;
  logic [1:0]         in_action_kind;
  logic [STATE_W-1:0] in_target;
  logic [RULE_W-1:0]  in_rule_index;
  logic [LHS_W-1:0]   in_rule_lhs;
  logic [LEN_W-1:0]   in_rule_length;
  logic [COL_W-1:0]   in_symbol;

  assign in_mode        = mode_e'(s_axis_tuser);
  assign in_row         = s_axis_tdata[5:0];
  assign in_column      = s_axis_tdata[10:6];
  assign in_action_kind = s_axis_tdata[12:11];
  assign in_target      = s_axis_tdata[18:13];
  assign in_rule_index  = s_axis_tdata[24:19];
  assign in_rule_lhs    = s_axis_tdata[28:25];
  assign in_rule_length = s_axis_tdata[32:29];
  assign in_symbol      = s_axis_tdata[37:33];

  state_e             state_q, state_d;
  logic [SPW-1:0]     sp_q, sp_d;
  logic [STATE_W-1:0] top_q, top_d;
  logic [RED_W-1:0]   red_q, red_d;
  logic [COL_W-1:0]   sym_q, sym_d;
  logic [RULE_W-1:0]  arg_q, arg_d;
  logic [LHS_W-1:0]   lhs_q, lhs_d;
  logic               act_bad_q, act_bad_d;
  logic               goto_bad_q, goto_bad_d;

  logic               out_valid_q;
  res_e               out_kind_q;
  logic [RULE_W-1:0]  out_rule_q;
  logic [STATE_W-1:0] out_state_q;
  logic               out_last_q;

  logic               emit;
  res_e               e_kind;
  logic [RULE_W-1:0]  e_rule;
  logic [STATE_W-1:0] e_state;
  logic               e_last;
  logic               emit_ok;
  logic               in_acc;
  logic               do_fail;

  tbl_ctl_t                ctl;
  logic [AAW-1:0]          act_waddr, act_raddr;
  logic [ACT_ENTRY_W-1:0]  act_rdata;
  logic [GAW-1:0]          goto_waddr, goto_raddr;
  logic [GOTO_ENTRY_W-1:0] goto_rdata;
  logic [RAW-1:0]          rule_waddr, rule_raddr;
  logic [RULE_ENTRY_W-1:0] rule_rdata;

  logic               stk_we, stk_re;
  logic [STKW-1:0]    stk_waddr, stk_raddr;
  logic [STATE_W-1:0] stk_wdata, stk_rdata;

  logic               act_issue;
  logic [STATE_W-1:0] act_st;
  logic [COL_W-1:0]   act_col;

  act_e               a_kind;
  logic [RULE_W-1:0]  a_arg;
  logic [LEN_W-1:0]   r_len;
  logic               g_valid;
  logic [STATE_W-1:0] g_state;

  assign emit_ok       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && emit_ok;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign act_waddr  = AAW'(AAW'(in_row) * AAW'(TERMINALS) + AAW'(in_column));
  assign goto_waddr = GAW'(GAW'(in_row) * GAW'(NONTERMINALS) + GAW'(in_column));
  assign rule_waddr = RAW'(in_rule_index);

  assign a_kind  = act_bad_q ? ACT_EMPTY : act_e'(act_rdata[7:6]);
  assign a_arg   = act_rdata[5:0];
  assign r_len   = rule_rdata[3:0];
  assign g_valid = !goto_bad_q && goto_rdata[6];
  assign g_state = goto_rdata[5:0];

  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    top_d      = top_q;
    red_d      = red_q;
    sym_d      = sym_q;
    arg_d      = arg_q;
    lhs_d      = lhs_q;
    act_bad_d  = act_bad_q;
    goto_bad_d = goto_bad_q;
    ctl        = '0;
    act_raddr  = '0;
    goto_raddr = '0;
    rule_raddr = RAW'(a_arg);
    stk_we     = 1'b0;
    stk_waddr  = STKW'(sp_q);
    stk_wdata  = a_arg;
    stk_re     = 1'b0;
    stk_raddr  = '0;
    emit       = 1'b0;
    e_kind     = RES_LOAD;
    e_rule     = '0;
    e_state    = top_q;
    e_last     = 1'b1;
    do_fail    = 1'b0;
    act_issue  = 1'b0;
    act_st     = top_q;
    act_col    = in_symbol;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_ACTION: begin
              ctl.act_we = (32'(in_row) < STATES) && (32'(in_column) < TERMINALS);
              emit       = 1'b1;
            end
            MODE_GOTO: begin
              ctl.goto_we = (32'(in_row) < STATES) && (32'(in_column) < NONTERMINALS);
              emit        = 1'b1;
            end
            MODE_RULE: begin
              ctl.rule_we = 32'(in_rule_index) < RULES;
              emit        = 1'b1;
            end
            MODE_PARSE: begin
              sym_d     = in_symbol;
              red_d     = '0;
              act_issue = 1'b1;
              state_d   = ST_ACT;
            end
            default: ;
          endcase
        end
      end
      ST_ACT: begin
        if (emit_ok) begin
          case (a_kind)
            ACT_ACCEPT: begin
              emit    = 1'b1;
              e_kind  = RES_ACCEPT;
              e_state = '0;
              sp_d    = SPW'(1);
              top_d   = '0;
              state_d = ST_IDLE;
            end
            ACT_SHIFT: begin
              if (32'(sp_q) >= STACK_DEPTH) begin
                do_fail = 1'b1;
              end else begin
                stk_we  = 1'b1;
                sp_d    = sp_q + SPW'(1);
                top_d   = a_arg;
                emit    = 1'b1;
                e_kind  = RES_SHIFT;
                e_state = a_arg;
                state_d = ST_IDLE;
              end
            end
            ACT_REDUCE: begin
              if (red_q >= RED_W'(MAX_RED) || 32'(a_arg) >= RULES) begin
                do_fail = 1'b1;
              end else begin
                ctl.rule_re = 1'b1;
                arg_d       = a_arg;
                state_d     = ST_RULE;
              end
            end
            default: do_fail = 1'b1;
          endcase
        end
      end
      ST_RULE: begin
        if (emit_ok) begin
          if (32'(r_len) >= 32'(sp_q)) begin
            do_fail = 1'b1;
          end else begin
            sp_d      = sp_q - SPW'(r_len);
            stk_re    = 1'b1;
            stk_raddr = STKW'(sp_q - SPW'(r_len) - SPW'(1));
            lhs_d     = rule_rdata[7:4];
            state_d   = ST_STK;
          end
        end
      end
      ST_STK: begin
        goto_bad_d = !((32'(stk_rdata) < STATES) && (32'(lhs_q) < NONTERMINALS));
        ctl.goto_re = !goto_bad_d;
        goto_raddr  = GAW'(GAW'(stk_rdata) * GAW'(NONTERMINALS) + GAW'(lhs_q));
        state_d     = ST_GOTO;
      end
      ST_GOTO: begin
        if (emit_ok) begin
          if (!g_valid || 32'(sp_q) >= STACK_DEPTH) begin
            do_fail = 1'b1;
          end else begin
            stk_we    = 1'b1;
            stk_wdata = g_state;
            sp_d      = sp_q + SPW'(1);
            top_d     = g_state;
            red_d     = red_q + RED_W'(1);
            emit      = 1'b1;
            e_kind    = RES_REDUCE;
            e_rule    = arg_q;
            e_state   = g_state;
            e_last    = 1'b0;
            act_issue = 1'b1;
            act_st    = g_state;
            act_col   = sym_q;
            state_d   = ST_ACT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_fail) begin
      emit    = 1'b1;
      e_kind  = RES_ERROR;
      e_rule  = '0;
      e_state = '0;
      e_last  = 1'b1;
      sp_d    = SPW'(1);
      top_d   = '0;
      state_d = ST_IDLE;
    end

    if (act_issue) begin
      act_bad_d  = !((32'(act_st) < STATES) && (32'(act_col) < TERMINALS));
      ctl.act_re = !act_bad_d;
      act_raddr  = AAW'(AAW'(act_st) * AAW'(TERMINALS) + AAW'(act_col));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= SPW'(1);
      top_q       <= '0;
      red_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      top_q   <= top_d;
      red_q   <= red_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    arg_q      <= arg_d;
    lhs_q      <= lhs_d;
    act_bad_q  <= act_bad_d;
    goto_bad_q <= goto_bad_d;
    if (emit) begin
      out_kind_q  <= e_kind;
      out_rule_q  <= e_rule;
      out_state_q <= e_state;
      out_last_q  <= e_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_state_q, out_rule_q, out_kind_q};
  assign m_axis_tlast  = out_last_q;

  lrsr_tables #(
    .STATES       (STATES),
    .TERMINALS    (TERMINALS),
    .NONTERMINALS (NONTERMINALS),
    .RULES        (RULES)
  ) u_tables (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .act_waddr_i  (act_waddr),
    .act_wdata_i  ({in_action_kind, in_target}),
    .act_raddr_i  (act_raddr),
    .act_rdata_o  (act_rdata),
    .goto_waddr_i (goto_waddr),
    .goto_wdata_i ({in_action_kind == GOTO_KIND_VALID, in_target}),
    .goto_raddr_i (goto_raddr),
    .goto_rdata_o (goto_rdata),
    .rule_waddr_i (rule_waddr),
    .rule_wdata_i ({in_rule_lhs, in_rule_length}),
    .rule_raddr_i (rule_raddr),
    .rule_rdata_o (rule_rdata)
  );

  lrsr_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q >= SPW'(1)) && (32'(sp_q) <= STACK_DEPTH))
    else $error("stack pointer out of range");

  a_red_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q <= RED_W'(MAX_RED))
    else $error("reduction count beyond limit");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (e_kind == RES_ACCEPT || e_kind == RES_ERROR)) |=>
    (sp_q == SPW'(1) && top_q == '0))
    else $error("stack not reset after accept or error");

  a_bottom_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |-> (stk_waddr != '0))
    else $error("write to bottom stack entry");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (out_kind_q != RES_REDUCE)))
    else $error("last flag does not match result kind");

endmodule
`default_nettype wire
